/* rtl/core/bba_pkg.sv */
`default_nettype none

package bba_pkg;

   localparam int ORDER_W = 5;
   localparam int BYTES_W = 16;
   localparam int OFFSET_W = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TOP_ORDER = 1'b0;
   localparam logic [ORDER_W-1:0] TOP_ORDER_RESET = 5'd16;

   typedef struct packed {
      logic operation;
      logic [BYTES_W-1:0] request_bytes;
      logic [OFFSET_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic success;
      logic [OFFSET_W-1:0] granted_offset;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/bba_stream_if.sv */
`default_nettype none

interface bba_stream_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bba_hdr_mem.sv */
`default_nettype none

module bba_hdr_mem #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 34
) (
   input wire logic clock,
   input wire logic re,
   input wire logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata,
   input wire logic we,
   input wire logic [ADDR_W-1:0] waddr,
   input wire logic [DATA_W-1:0] wdata
);

   logic [DATA_W-1:0] mem [1 << ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/bba_ctrl.sv */
`default_nettype none

module bba_ctrl #(
   parameter int MAX_LEVEL = 16,
   parameter int MIN_LEVEL = 3,
   parameter int HEADER_BYTES = 24,
   parameter int ALIGN_BYTES = 8
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic cfg_we,
   input wire logic [bba_pkg::ORDER_W-1:0] cfg_value,
   output logic [bba_pkg::ORDER_W-1:0] top_order,
   input wire logic req_valid,
   output logic req_ready,
   input wire bba_pkg::req_type req_data,
   output logic res_valid,
   input wire logic res_ready,
   output bba_pkg::rsp_type res_data,
   output logic mem_re,
   output logic [MAX_LEVEL-MIN_LEVEL-1:0] mem_raddr,
   input wire logic [2*(MAX_LEVEL-MIN_LEVEL)+8-1:0] mem_rdata,
   output logic mem_we,
   output logic [MAX_LEVEL-MIN_LEVEL-1:0] mem_waddr,
   output logic [2*(MAX_LEVEL-MIN_LEVEL)+8-1:0] mem_wdata
);

   localparam int OW = bba_pkg::ORDER_W;
   localparam int SW = MAX_LEVEL - MIN_LEVEL;
   localparam int LISTS = SW + 1;
   localparam int LW = $clog2(LISTS);
   localparam int SZW = bba_pkg::BYTES_W + 1;
   localparam logic [OW-1:0] MIN_O = OW'(MIN_LEVEL);
   localparam logic [OW-1:0] MAX_O = OW'(MAX_LEVEL);
   localparam logic [OW-1:0] TOP_RST =
      (bba_pkg::TOP_ORDER_RESET < MIN_O) ? MIN_O :
      ((bba_pkg::TOP_ORDER_RESET > MAX_O) ? MAX_O : bba_pkg::TOP_ORDER_RESET);
   localparam logic [OW-1:0] ORDER_LIMIT = 5'd31;

   typedef struct packed {
      logic [OW-1:0] order;
      logic free;
      logic [SW-1:0] next;
      logic next_ok;
      logic [SW-1:0] prev;
      logic prev_ok;
   } hdr_type;

   localparam logic [4:0] S_INIT = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_ASIZE = 5'd2;
   localparam logic [4:0] S_ASCAN = 5'd3;
   localparam logic [4:0] S_AGET = 5'd4;
   localparam logic [4:0] S_ASPLIT = 5'd5;
   localparam logic [4:0] S_FGET = 5'd6;
   localparam logic [4:0] S_FMRG = 5'd7;
   localparam logic [4:0] S_FBUD = 5'd8;
   localparam logic [4:0] S_FABS = 5'd9;
   localparam logic [4:0] S_ULP = 5'd10;
   localparam logic [4:0] S_ULPW = 5'd11;
   localparam logic [4:0] S_ULN = 5'd12;
   localparam logic [4:0] S_ULNW = 5'd13;
   localparam logic [4:0] S_PSW = 5'd14;
   localparam logic [4:0] S_PSR = 5'd15;
   localparam logic [4:0] S_PSRW = 5'd16;
   localparam logic [4:0] S_DONE = 5'd17;

   localparam logic [1:0] R_SPLIT = 2'd0;
   localparam logic [1:0] R_ABSORB = 2'd1;
   localparam logic [1:0] R_DONE = 2'd2;

   function automatic logic [LW-1:0] lidx(input logic [OW-1:0] o);
      lidx = LW'(o - MIN_O);
   endfunction

   function automatic logic [SW-1:0] buddy(input logic [SW-1:0] s, input logic [OW-1:0] o);
      buddy = s ^ (SW'(1) << (o - MIN_O));
   endfunction

   logic [31:0] cap_tab [32];

   for (genvar g = 0; g < 32; g++) begin : g_cap
      localparam longint unsigned CAPV = ((64'd1 << g) / ALIGN_BYTES) * ALIGN_BYTES;
      assign cap_tab[g] = 32'(CAPV);
   end

   logic [4:0] state_ff, state_in;
   logic [1:0] ret_ff, ret_in;
   logic [OW-1:0] top_ff, top_in;
   logic [OW-1:0] want_ff, want_in;
   logic [OW-1:0] scan_ff, scan_in;
   logic [SZW-1:0] size_ff, size_in;
   logic [SW-1:0] s_ff, s_in;
   logic [SW-1:0] b_ff, b_in;
   hdr_type cur_ff, cur_in;
   hdr_type hb_ff, hb_in;
   logic [SW-1:0] px_ff, px_in;
   logic [OW-1:0] pord_ff, pord_in;
   logic [SW-1:0] ph_ff, ph_in;
   logic [SW-1:0] head_ff [LISTS];
   logic [SW-1:0] head_in [LISTS];
   logic [LISTS-1:0] hok_ff, hok_in;
   logic ok_ff, ok_in;
   logic [bba_pkg::OFFSET_W-1:0] gofs_ff, gofs_in;

   hdr_type rdh;
   logic [4:0] ret_state;
   logic [OW-1:0] sat_order;

   assign rdh = hdr_type'(mem_rdata);
   assign top_order = top_ff;
   assign res_data = '{success: ok_ff, granted_offset: gofs_ff};

   always_comb begin
      priority if (cfg_value < MIN_O) begin
         sat_order = MIN_O;
      end else if (cfg_value > MAX_O) begin
         sat_order = MAX_O;
      end else begin
         sat_order = cfg_value;
      end
   end

   always_comb begin
      unique case (ret_ff)
         R_SPLIT: ret_state = S_ASPLIT;
         R_ABSORB: ret_state = S_FABS;
         default: ret_state = S_DONE;
      endcase
   end

   always_comb begin
      hdr_type t;
      logic [LW-1:0] li;
      logic [SW-1:0] fs;
      logic [SW-1:0] amask;

      state_in = state_ff;
      ret_in = ret_ff;
      top_in = top_ff;
      want_in = want_ff;
      scan_in = scan_ff;
      size_in = size_ff;
      s_in = s_ff;
      b_in = b_ff;
      cur_in = cur_ff;
      hb_in = hb_ff;
      px_in = px_ff;
      pord_in = pord_ff;
      ph_in = ph_ff;
      head_in = head_ff;
      hok_in = hok_ff;
      ok_in = ok_ff;
      gofs_in = gofs_ff;
      mem_re = 1'b0;
      mem_raddr = s_ff;
      mem_we = 1'b0;
      mem_waddr = s_ff;
      mem_wdata = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;
      t = rdh;
      li = lidx(pord_ff);
      fs = SW'(32'(req_data.block_offset) >> MIN_LEVEL);
      amask = (SW'(1) << (rdh.order - MIN_O)) - SW'(1);

      unique case (state_ff)
         S_INIT: begin
            t = '0;
            t.order = top_ff;
            t.free = 1'b1;
            mem_we = 1'b1;
            mem_waddr = '0;
            mem_wdata = t;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cfg_we) begin
               top_in = sat_order;
               hok_in = '0;
               hok_in[lidx(sat_order)] = 1'b1;
               head_in[lidx(sat_order)] = '0;
               t = '0;
               t.order = sat_order;
               t.free = 1'b1;
               mem_we = 1'b1;
               mem_waddr = '0;
               mem_wdata = t;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  ok_in = 1'b0;
                  gofs_in = '0;
                  if (req_data.operation == bba_pkg::OP_ALLOC) begin
                     if (req_data.request_bytes == '0) begin
                        state_in = S_DONE;
                     end else begin
                        size_in = SZW'(req_data.request_bytes) + SZW'(HEADER_BYTES);
                        want_in = MIN_O;
                        state_in = S_ASIZE;
                     end
                  end else if (req_data.block_offset[MIN_LEVEL-1:0] != '0) begin
                     state_in = S_DONE;
                  end else if ((32'(req_data.block_offset) >> top_ff) != 32'd0) begin
                     state_in = S_DONE;
                  end else begin
                     s_in = fs;
                     mem_re = 1'b1;
                     mem_raddr = fs;
                     state_in = S_FGET;
                  end
               end
            end
         end
         S_ASIZE: begin
            if (want_ff != ORDER_LIMIT && 32'(size_ff) > cap_tab[want_ff]) begin
               want_in = want_ff + OW'(1);
            end else if (want_ff > top_ff) begin
               state_in = S_DONE;
            end else begin
               scan_in = want_ff;
               state_in = S_ASCAN;
            end
         end
         S_ASCAN: begin
            if (scan_ff > top_ff) begin
               state_in = S_DONE;
            end else if (hok_ff[lidx(scan_ff)]) begin
               s_in = head_ff[lidx(scan_ff)];
               mem_re = 1'b1;
               mem_raddr = head_ff[lidx(scan_ff)];
               state_in = S_AGET;
            end else begin
               scan_in = scan_ff + OW'(1);
            end
         end
         S_AGET: begin
            cur_in = rdh;
            hb_in = rdh;
            ret_in = R_SPLIT;
            state_in = S_ULP;
         end
         S_ULP: begin
            if (hb_ff.prev_ok) begin
               mem_re = 1'b1;
               mem_raddr = hb_ff.prev;
               state_in = S_ULPW;
            end else begin
               head_in[lidx(hb_ff.order)] = hb_ff.next;
               hok_in[lidx(hb_ff.order)] = hb_ff.next_ok;
               state_in = S_ULN;
            end
         end
         S_ULPW: begin
            t.next = hb_ff.next;
            t.next_ok = hb_ff.next_ok;
            mem_we = 1'b1;
            mem_waddr = hb_ff.prev;
            mem_wdata = t;
            state_in = S_ULN;
         end
         S_ULN: begin
            if (hb_ff.next_ok) begin
               mem_re = 1'b1;
               mem_raddr = hb_ff.next;
               state_in = S_ULNW;
            end else begin
               state_in = ret_state;
            end
         end
         S_ULNW: begin
            t.prev = hb_ff.prev;
            t.prev_ok = hb_ff.prev_ok;
            mem_we = 1'b1;
            mem_waddr = hb_ff.next;
            mem_wdata = t;
            state_in = ret_state;
         end
         S_ASPLIT: begin
            if (cur_ff.order > want_ff) begin
               cur_in.order = cur_ff.order - OW'(1);
               px_in = buddy(s_ff, cur_ff.order - OW'(1));
               pord_in = cur_ff.order - OW'(1);
               ret_in = R_SPLIT;
               state_in = S_PSW;
            end else begin
               t = cur_ff;
               t.free = 1'b0;
               mem_we = 1'b1;
               mem_waddr = s_ff;
               mem_wdata = t;
               ok_in = 1'b1;
               gofs_in = 16'(32'(s_ff) << MIN_LEVEL);
               state_in = S_DONE;
            end
         end
         S_PSW: begin
            t = '0;
            t.order = pord_ff;
            t.free = 1'b1;
            t.next = head_ff[li];
            t.next_ok = hok_ff[li];
            mem_we = 1'b1;
            mem_waddr = px_ff;
            mem_wdata = t;
            ph_in = head_ff[li];
            head_in[li] = px_ff;
            hok_in[li] = 1'b1;
            state_in = hok_ff[li] ? S_PSR : ret_state;
         end
         S_PSR: begin
            mem_re = 1'b1;
            mem_raddr = ph_ff;
            state_in = S_PSRW;
         end
         S_PSRW: begin
            t.prev = px_ff;
            t.prev_ok = 1'b1;
            mem_we = 1'b1;
            mem_waddr = ph_ff;
            mem_wdata = t;
            state_in = ret_state;
         end
         S_FGET: begin
            if (rdh.free || rdh.order < MIN_O || rdh.order > top_ff ||
                (s_ff & amask) != '0) begin
               state_in = S_DONE;
            end else begin
               cur_in = rdh;
               cur_in.free = 1'b1;
               state_in = S_FMRG;
            end
         end
         S_FMRG: begin
            if (cur_ff.order < top_ff) begin
               b_in = buddy(s_ff, cur_ff.order);
               mem_re = 1'b1;
               mem_raddr = buddy(s_ff, cur_ff.order);
               state_in = S_FBUD;
            end else begin
               px_in = s_ff;
               pord_in = cur_ff.order;
               ret_in = R_DONE;
               ok_in = 1'b1;
               state_in = S_PSW;
            end
         end
         S_FBUD: begin
            if (!rdh.free || rdh.order != cur_ff.order) begin
               px_in = s_ff;
               pord_in = cur_ff.order;
               ret_in = R_DONE;
               ok_in = 1'b1;
               state_in = S_PSW;
            end else begin
               hb_in = rdh;
               ret_in = R_ABSORB;
               state_in = S_ULP;
            end
         end
         S_FABS: begin
            mem_we = 1'b1;
            if (b_ff < s_ff) begin
               t = cur_ff;
               t.free = 1'b0;
               mem_waddr = s_ff;
               mem_wdata = t;
               s_in = b_ff;
               cur_in = hb_ff;
               cur_in.order = cur_ff.order + OW'(1);
            end else begin
               t = hb_ff;
               t.free = 1'b0;
               mem_waddr = b_ff;
               mem_wdata = t;
               cur_in.order = cur_ff.order + OW'(1);
            end
            state_in = S_FMRG;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ret_ff <= R_DONE;
         top_ff <= TOP_RST;
         hok_ff <= LISTS'(1) << lidx(TOP_RST);
         head_ff[lidx(TOP_RST)] <= '0;
         ok_ff <= 1'b0;
         gofs_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         top_ff <= top_in;
         hok_ff <= hok_in;
         head_ff <= head_in;
         ok_ff <= ok_in;
         gofs_ff <= gofs_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      scan_ff <= scan_in;
      size_ff <= size_in;
      s_ff <= s_in;
      b_ff <= b_in;
      cur_ff <= cur_in;
      hb_ff <= hb_in;
      px_ff <= px_in;
      pord_ff <= pord_in;
      ph_ff <= ph_in;
   end

`ifndef SYNTHESIS
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_re && mem_we))
      else $error("Header memory read and written in the same cycle.");

   a_split_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ASPLIT |-> cur_ff.order >= want_ff)
      else $error("Split went below the wanted order.");

   a_merge_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FMRG |-> (cur_ff.order >= MIN_O && cur_ff.order <= top_ff))
      else $error("Merge order left the managed range.");

   a_done_after_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("Accepted item produced no work.");
`endif

endmodule

`default_nettype wire

/* rtl/core/buddy_block_allocator.sv */
// Channel   Direction  Handshake     Payload
// req_ch    in         valid/ready   operation, request_bytes, block_offset
// rsp_ch    out        valid/ready   success, granted_offset
// APB       in         psel/penable  top_order at byte address 0
//
// One item is worked on at a time. The header memory is never read and written in the
// same cycle, so each split or merge level costs separate header reads and writes, and
// the order search and the list scan step through the orders one at a time.
// After reset the block writes the header of slot 0 before taking items.
// A finished result waits in an output register while the next item is accepted.
`default_nettype none

module buddy_block_allocator #(
   parameter int MAX_LEVEL = 16,
   parameter int MIN_LEVEL = 3,
   parameter int HEADER_BYTES = 24,
   parameter int ALIGN_BYTES = 8
) (
   input wire logic clock,
   input wire logic reset,
   bba_stream_if.sink req_ch,
   bba_stream_if.source rsp_ch,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [bba_pkg::CSR_ADDR_W-1:0] paddr,
   input wire logic [bba_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   localparam int SW = MAX_LEVEL - MIN_LEVEL;
   localparam int HW = 2 * SW + 8;

   logic cfg_we;
   logic [bba_pkg::ORDER_W-1:0] top_order;
   logic res_valid;
   logic res_ready;
   bba_pkg::rsp_type res_data;
   logic mem_re;
   logic [SW-1:0] mem_raddr;
   logic [HW-1:0] mem_rdata;
   logic mem_we;
   logic [SW-1:0] mem_waddr;
   logic [HW-1:0] mem_wdata;

   logic rsp_vld_ff, rsp_vld_in;
   bba_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2] == bba_pkg::REG_TOP_ORDER);
   assign prdata = (paddr[2] == bba_pkg::REG_TOP_ORDER) ?
                   bba_pkg::CSR_DATA_W'(top_order) : '0;

   bba_ctrl #(
      .MAX_LEVEL(MAX_LEVEL),
      .MIN_LEVEL(MIN_LEVEL),
      .HEADER_BYTES(HEADER_BYTES),
      .ALIGN_BYTES(ALIGN_BYTES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .cfg_we(cfg_we),
      .cfg_value(pwdata[bba_pkg::ORDER_W-1:0]),
      .top_order(top_order),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_data(req_ch.data),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res_data(res_data),
      .mem_re(mem_re),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata)
   );

   bba_hdr_mem #(
      .ADDR_W(SW),
      .DATA_W(HW)
   ) u_hdr_mem (
      .clock(clock),
      .re(mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata)
   );

   assign res_ready = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_vld_in = 1'b1;
         rsp_data_in = res_data;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.data = rsp_data_ff;

endmodule

`default_nettype wire

/* sim/bba_checker.sv */
`default_nettype none

module bba_checker
   import bba_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_type rsp_data,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic pready,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [CSR_DATA_W-1:0] pwdata,
   output int errors,
   output int owed
);

   localparam int LOW_LOG2 = 3;
   localparam int HIGH_LOG2 = 16;
   localparam int SLOT_COUNT = 1 << (HIGH_LOG2 - LOW_LOG2);
   localparam int ORDER_COUNT = HIGH_LOG2 - LOW_LOG2 + 1;
   localparam int HDR_BYTES = 24;
   localparam int ALIGN = 8;

   bit [ORDER_W-1:0] blk_order [SLOT_COUNT];
   bit blk_free [SLOT_COUNT];
   bit [12:0] link_next [SLOT_COUNT];
   bit [12:0] link_prev [SLOT_COUNT];
   bit next_valid [SLOT_COUNT];
   bit prev_valid [SLOT_COUNT];
   bit [12:0] head [ORDER_COUNT];
   bit head_valid [ORDER_COUNT];
   int region_order;
   rsp_type expected_rsps [$];

   function automatic void push_block(int s);
      int o;
      int li;
      o = blk_order[s];
      if (o < LOW_LOG2 || o > HIGH_LOG2) return;
      li = o - LOW_LOG2;
      blk_free[s] = 1;
      link_next[s] = head[li];
      next_valid[s] = head_valid[li];
      prev_valid[s] = 0;
      link_prev[s] = 0;
      if (head_valid[li]) begin
         link_prev[head[li]] = 13'(s);
         prev_valid[head[li]] = 1;
      end
      head[li] = 13'(s);
      head_valid[li] = 1;
   endfunction

   function automatic void unlink_block(int s);
      int o;
      int li;
      o = blk_order[s];
      if (o < LOW_LOG2 || o > HIGH_LOG2) return;
      li = o - LOW_LOG2;
      if (prev_valid[s]) begin
         link_next[link_prev[s]] = link_next[s];
         next_valid[link_prev[s]] = next_valid[s];
      end else begin
         head[li] = link_next[s];
         head_valid[li] = next_valid[s];
      end
      if (next_valid[s]) begin
         link_prev[link_next[s]] = link_prev[s];
         prev_valid[link_next[s]] = prev_valid[s];
      end
   endfunction

   function automatic void restart_region(int top);
      region_order = top < LOW_LOG2 ? LOW_LOG2 : (top > HIGH_LOG2 ? HIGH_LOG2 : top);
      foreach (head_valid[i]) begin
         head_valid[i] = 0;
         head[i] = 0;
      end
      blk_order[0] = ORDER_W'(region_order);
      push_block(0);
   endfunction

   function automatic bit allocate(int req, output int where);
      int size;
      int want;
      int s;
      int b;
      where = 0;
      if (req == 0) return 0;
      size = ((req + HDR_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
      want = LOW_LOG2;
      while (want < 31 && (1 << want) < size) want++;
      if (want > region_order) return 0;
      for (int o = want; o <= region_order; o++) begin
         if (o - LOW_LOG2 >= ORDER_COUNT || !head_valid[o - LOW_LOG2]) continue;
         s = head[o - LOW_LOG2];
         unlink_block(s);
         while (blk_order[s] > want) begin
            blk_order[s] = blk_order[s] - 1;
            b = (s ^ (1 << (blk_order[s] - LOW_LOG2))) & (SLOT_COUNT - 1);
            blk_order[b] = blk_order[s];
            push_block(b);
         end
         blk_free[s] = 0;
         where = s << LOW_LOG2;
         return 1;
      end
      return 0;
   endfunction

   function automatic bit release_block(int off);
      int s;
      int o;
      int b;
      int t;
      if (off % (1 << LOW_LOG2) != 0) return 0;
      if (off >= (1 << region_order)) return 0;
      s = off >> LOW_LOG2;
      o = blk_order[s];
      if (blk_free[s] || o < LOW_LOG2 || o > region_order) return 0;
      if ((s & ((1 << (o - LOW_LOG2)) - 1)) != 0) return 0;
      blk_free[s] = 1;
      while (blk_order[s] < region_order) begin
         b = (s ^ (1 << (blk_order[s] - LOW_LOG2))) & (SLOT_COUNT - 1);
         if (!blk_free[b] || blk_order[b] != blk_order[s]) break;
         unlink_block(b);
         if (b < s) begin
            t = s;
            s = b;
            b = t;
         end
         blk_free[b] = 0;
         blk_order[s] = blk_order[s] + 1;
      end
      push_block(s);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      int where;
      bit ok;
      if (reset) begin
         expected_rsps.delete();
         restart_region(int'(TOP_ORDER_RESET));
      end else begin
         if (psel && penable && pwrite && pready && paddr == (CSR_ADDR_W'(REG_TOP_ORDER) << 2))
            restart_region(int'(pwdata[ORDER_W-1:0]));
         if (req_valid && req_ready) begin
            if (req_data.operation == OP_ALLOC) begin
               ok = allocate(int'(req_data.request_bytes), where);
            end else begin
               ok = release_block(int'(req_data.block_offset));
               where = 0;
            end
            exp_rsp.success = ok;
            exp_rsp.granted_offset = ok ? OFFSET_W'(where) : '0;
            expected_rsps.push_back(exp_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("unexpected item: success %0d offset %0h",
                  rsp_data.success, rsp_data.granted_offset);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (exp_rsp.success !== rsp_data.success
                     || exp_rsp.granted_offset !== rsp_data.granted_offset) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch: expected success %0d offset %0h, got %0d %0h",
                        exp_rsp.success, exp_rsp.granted_offset,
                        rsp_data.success, rsp_data.granted_offset);
               end
            end
         end
      end
      owed <= expected_rsps.size();
   end

   initial begin
      errors = 0;
      owed = 0;
   end

endmodule

`default_nettype wire

/* sim/tb_buddy_block_allocator.sv */
`default_nettype none

module tb_buddy_block_allocator;
   import bba_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 150;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   int errors;
   int owed;
   int sent = 0;
   int received = 0;
   int region_order = 16;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit calm = 0;
   bit steady_rsp = 0;
   bit alloc_pending [$];
   logic [OFFSET_W-1:0] live_blocks [$];
   logic [OFFSET_W-1:0] stale_blocks [$];

   bba_stream_if #(.payload_type(req_type)) req_ch ();
   bba_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   buddy_block_allocator DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bba_checker u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .errors(errors), .owed(owed)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 0;
      end else if (!calm && !steady_rsp && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
      end
   end

   always @(posedge clock) begin
      bit was_alloc;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sent++;
            alloc_pending.push_back(req_ch.data.operation == OP_ALLOC);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            received++;
            if (alloc_pending.size() > 0) begin
               was_alloc = alloc_pending.pop_front();
               if (was_alloc && rsp_ch.data.success)
                  live_blocks.push_back(rsp_ch.data.granted_offset);
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(logic op, logic [BYTES_W-1:0] bytes, logic [OFFSET_W-1:0] off);
      req_type it;
      it.operation = op;
      it.request_bytes = bytes;
      it.block_offset = off;
      req_ch.valid <= 1;
      req_ch.data <= it;
      do @(posedge clock); while (!req_ch.ready);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (received != sent) @(posedge clock);
   endtask

   task automatic write_top_order(int value);
      drain();
      repeat (120) @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= CSR_ADDR_W'(REG_TOP_ORDER) << 2;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
      region_order = value < 3 ? 3 : (value > 16 ? 16 : value);
      live_blocks.delete();
      stale_blocks.delete();
   endtask

   task automatic free_live(int idx);
      logic [OFFSET_W-1:0] off;
      off = live_blocks[idx];
      live_blocks.delete(idx);
      stale_blocks.push_back(off);
      if (stale_blocks.size() > 32) void'(stale_blocks.pop_front());
      send_item(OP_FREE, BYTES_W'($urandom), off);
   endtask

   task automatic random_item();
      int pick;
      int k;
      logic [OFFSET_W-1:0] off;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         k = $urandom_range(0, region_order);
         if ($urandom_range(0, 19) == 0) k = 16;
         send_item(OP_ALLOC, BYTES_W'($urandom_range(0, (1 << k) - 1)),
            OFFSET_W'($urandom));
      end else if (pick < 85) begin
         if (alloc_pending.size() > 0 && live_blocks.size() == 0 && received != sent) begin
            req_ch.valid <= 0;
            while (alloc_pending.size() > 0 && live_blocks.size() == 0 && received != sent)
               @(posedge clock);
         end
         if (live_blocks.size() > 0)
            free_live($urandom_range(0, live_blocks.size() - 1));
         else
            send_item(OP_ALLOC, BYTES_W'($urandom_range(1, 64)), OFFSET_W'($urandom));
      end else if (pick < 91) begin
         off = OFFSET_W'($urandom);
         if (off[2:0] == 3'b000) off[$urandom_range(0, 2)] = 1'b1;
         send_item(OP_FREE, BYTES_W'($urandom), off);
      end else if (pick < 95 && region_order < 16) begin
         off = OFFSET_W'($urandom_range(1 << region_order, 65535));
         off[2:0] = 3'b000;
         send_item(OP_FREE, BYTES_W'($urandom), off);
      end else if (stale_blocks.size() > 0) begin
         send_item(OP_FREE, BYTES_W'($urandom),
            stale_blocks[$urandom_range(0, stale_blocks.size() - 1)]);
      end else begin
         send_item(OP_ALLOC, 16'hFFFF, 16'hFFFF);
      end
   endtask

   initial begin
      int settings [$];
      settings = '{3, 20, 0, 8, 12, 31, 5, 16};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(OP_ALLOC, 16'd0, 16'd0);
      send_item(OP_ALLOC, 16'hFFFF, 16'd0);
      send_item(OP_ALLOC, 16'd65512, 16'hFFFF);
      send_item(OP_ALLOC, 16'd1, 16'd0);
      send_item(OP_FREE, 16'hFFFF, 16'd0);
      send_item(OP_FREE, 16'd0, 16'd0);
      send_item(OP_FREE, 16'd0, 16'd4);
      send_item(OP_ALLOC, 16'd8, 16'd0);
      send_item(OP_ALLOC, 16'd9, 16'd0);
      send_item(OP_ALLOC, 16'd1000, 16'd0);
      send_item(OP_ALLOC, 16'd40000, 16'd0);
      send_item(OP_FREE, 16'd0, 16'd64);
      send_item(OP_FREE, 16'd0, 16'd32);
      send_item(OP_FREE, 16'd0, 16'd32);
      send_item(OP_FREE, 16'd0, 16'd0);
      send_item(OP_FREE, 16'd0, 16'd1024);
      drain();

      for (int phase = 0; phase <= settings.size(); phase++) begin
         steady_rsp = (phase % 3 == 2);
         calm = (phase == settings.size());
         for (int n = 0; n < 140; n++) begin
            if (n == 70) drain();
            random_item();
         end
         if (phase < settings.size()) write_top_order(settings[phase]);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && owed == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
